// File: rtl/mer_pkg.sv
// mer_pkg: shared constants, state and command types of the midpoint ellipse rasterizer
// no dependencies; imported by every module of the block
`default_nettype none

package mer_pkg;

    localparam int AXIS_BITS_DEF = 10;
    localparam int DEC_W         = 48;
    localparam int PIX_W         = 13;
    localparam int CENTER_W      = 11;
    localparam int ADDR_W        = 3;
    localparam int DATA_W        = 32;

    localparam logic [CENTER_W-1:0] CENTER_X_RST = 11'd320;
    localparam logic [CENTER_W-1:0] CENTER_Y_RST = 11'd240;

    // register select taken from paddr[2]
    localparam logic REG_CENTER_X = 1'b0;
    localparam logic REG_CENTER_Y = 1'b1;

    localparam logic CMD_START = 1'b0;
    localparam logic CMD_STEP  = 1'b1;

    localparam logic [1:0] QUAD_PP = 2'd0;
    localparam logic [1:0] QUAD_MP = 2'd1;
    localparam logic [1:0] QUAD_PM = 2'd2;
    localparam logic [1:0] QUAD_MM = 2'd3;

    typedef enum logic [4:0] {
        S_IDLE,
        S_ST_SQA,
        S_ST_SQB,
        S_ST_AB,
        S_ST_FIN,
        S_CMP_BX,
        S_CMP_AY,
        S_CMP_EVAL,
        S_SW_TXSQ,
        S_SW_BTX,
        S_SW_YMSQ,
        S_SW_AYM,
        S_SW_AB,
        S_SW_FIN,
        S_EMIT,
        S_UP_XY,
        S_UP_BX,
        S_UP_AY,
        S_UP_FIN
    } state_t;

    typedef enum logic [3:0] {
        MUL_NONE,
        MUL_AA,
        MUL_BB,
        MUL_A2B,
        MUL_B2X,
        MUL_A2Y,
        MUL_TXTX,
        MUL_B2P,
        MUL_YMYM,
        MUL_A2P,
        MUL_A2B2
    } mul_op_t;

    typedef enum logic [2:0] {
        DEC_HOLD,
        DEC_START,
        DEC_SUB4P,
        DEC_LOADP,
        DEC_ADD4P,
        DEC_ADDEND,
        DEC_ADD8P,
        DEC_SUB8P
    } dec_op_t;

    typedef struct packed {
        mul_op_t mul_op;
        dec_op_t dec_op;
        logic    load_start;
        logic    load_a2;
        logic    load_b2;
        logic    save_t;
        logic    set_rtwo;
        logic    step_xy;
        logic    emit;
    } ctrl_cmd_t;

    typedef struct packed {
        logic gt;
        logic y_zero;
        logic rtwo;
        logic out_free;
        logic emit_last;
    } dp_stat_t;

endpackage

`default_nettype wire

// File: rtl/mer_ctrl.sv
// mer_ctrl: sequencer of the ellipse rasterizer, issues one datapath command per cycle
// depends on mer_pkg (state_t, ctrl_cmd_t, dp_stat_t)
`default_nettype none

module mer_ctrl
    import mer_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    input  wire logic      in_cmd,
    output logic           in_stall,
    input  wire dp_stat_t  stat,
    output ctrl_cmd_t      dp_cmd
);

    state_t state_reg, state_next;
    logic   busy_reg, busy_next;
    logic   accept;

    assign accept = in_valid && (state_reg == S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            busy_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            busy_reg  <= busy_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        busy_next  = busy_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (in_cmd == CMD_START)
                    begin
                        state_next = S_ST_SQA;
                        busy_next  = 1'b1;
                    end
                    else if (busy_reg)
                    begin
                        state_next = stat.rtwo ? S_EMIT : S_CMP_BX;
                    end
                end
            end
            S_ST_SQA:   state_next = S_ST_SQB;
            S_ST_SQB:   state_next = S_ST_AB;
            S_ST_AB:    state_next = S_ST_FIN;
            S_ST_FIN:   state_next = S_IDLE;
            S_CMP_BX:   state_next = S_CMP_AY;
            S_CMP_AY:   state_next = S_CMP_EVAL;
            S_CMP_EVAL: state_next = stat.gt ? S_SW_TXSQ : S_EMIT;
            S_SW_TXSQ:  state_next = S_SW_BTX;
            S_SW_BTX:   state_next = S_SW_YMSQ;
            S_SW_YMSQ:  state_next = S_SW_AYM;
            S_SW_AYM:   state_next = S_SW_AB;
            S_SW_AB:    state_next = S_SW_FIN;
            S_SW_FIN:   state_next = S_EMIT;
            S_EMIT:
            begin
                if (stat.out_free && stat.emit_last)
                begin
                    if (stat.y_zero)
                    begin
                        state_next = S_IDLE;
                        busy_next  = 1'b0;
                    end
                    else
                    begin
                        state_next = S_UP_XY;
                    end
                end
            end
            S_UP_XY:    state_next = S_UP_BX;
            S_UP_BX:    state_next = S_UP_AY;
            S_UP_AY:    state_next = S_UP_FIN;
            S_UP_FIN:   state_next = S_IDLE;
            default:    state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        in_stall          = (state_reg != S_IDLE);
        dp_cmd            = '0;
        dp_cmd.mul_op     = MUL_NONE;
        dp_cmd.dec_op     = DEC_HOLD;
        case (state_reg)
            S_IDLE:     dp_cmd.load_start = accept && (in_cmd == CMD_START);
            S_ST_SQA:   dp_cmd.mul_op = MUL_AA;
            S_ST_SQB:
            begin
                dp_cmd.load_a2 = 1'b1;
                dp_cmd.mul_op  = MUL_BB;
            end
            S_ST_AB:
            begin
                dp_cmd.load_b2 = 1'b1;
                dp_cmd.dec_op  = DEC_START;
                dp_cmd.mul_op  = MUL_A2B;
            end
            S_ST_FIN:   dp_cmd.dec_op = DEC_SUB4P;
            S_CMP_BX:   dp_cmd.mul_op = MUL_B2X;
            S_CMP_AY:
            begin
                dp_cmd.save_t = 1'b1;
                dp_cmd.mul_op = MUL_A2Y;
            end
            S_CMP_EVAL: dp_cmd.mul_op = MUL_NONE;
            S_SW_TXSQ:  dp_cmd.mul_op = MUL_TXTX;
            S_SW_BTX:   dp_cmd.mul_op = MUL_B2P;
            S_SW_YMSQ:
            begin
                dp_cmd.dec_op = DEC_LOADP;
                dp_cmd.mul_op = MUL_YMYM;
            end
            S_SW_AYM:   dp_cmd.mul_op = MUL_A2P;
            S_SW_AB:
            begin
                dp_cmd.dec_op = DEC_ADD4P;
                dp_cmd.mul_op = MUL_A2B2;
            end
            S_SW_FIN:
            begin
                dp_cmd.dec_op   = DEC_SUB4P;
                dp_cmd.set_rtwo = 1'b1;
            end
            S_EMIT:     dp_cmd.emit = 1'b1;
            S_UP_XY:
            begin
                dp_cmd.step_xy = 1'b1;
                dp_cmd.dec_op  = DEC_ADDEND;
            end
            S_UP_BX:    dp_cmd.mul_op = MUL_B2X;
            S_UP_AY:
            begin
                dp_cmd.dec_op = DEC_ADD8P;
                dp_cmd.mul_op = MUL_A2Y;
            end
            S_UP_FIN:   dp_cmd.dec_op = DEC_SUB8P;
            default:    dp_cmd.mul_op = MUL_NONE;
        endcase
    end

endmodule

`default_nettype wire

// File: rtl/mer_datapath.sv
// mer_datapath: point, decision and axis-square registers, shared multiplier, pixel output register
// depends on mer_pkg; driven by mer_ctrl through ctrl_cmd_t / dp_stat_t
`default_nettype none

module mer_datapath
    import mer_pkg::*;
#(
    parameter int AXIS_BITS = AXIS_BITS_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic [CENTER_W-1:0]   center_x,
    input  wire logic [CENTER_W-1:0]   center_y,
    input  wire logic [AXIS_BITS-1:0]  semi_axis_a,
    input  wire logic [AXIS_BITS-1:0]  semi_axis_b,
    input  wire ctrl_cmd_t             dp_cmd,
    output dp_stat_t                   stat,
    input  wire logic                  out_stall,
    output logic                       out_valid,
    output logic signed [PIX_W-1:0]    pixel_x,
    output logic signed [PIX_W-1:0]    pixel_y,
    output logic [1:0]                 quadrant,
    output logic                       last_of_step,
    output logic                       done_res
);

    localparam int POS_W  = AXIS_BITS + 1;
    localparam int SQ_W   = 2 * AXIS_BITS;
    localparam int TX_W   = AXIS_BITS + 2;
    localparam int MA_W   = SQ_W;
    localparam int MB_W   = SQ_W + 4;
    localparam int PROD_W = MA_W + MB_W;

    logic [AXIS_BITS-1:0] a_reg;
    logic [POS_W-1:0]     cur_x_reg, cur_x_next;
    logic [POS_W-1:0]     cur_y_reg, cur_y_next;
    logic [DEC_W-1:0]     dec_reg, dec_next;
    logic [SQ_W-1:0]      a2_reg, b2_reg;
    logic [PROD_W-1:0]    p_reg, t_reg;
    logic                 rtwo_reg;
    logic                 use_bx_reg, use_bx_next;
    logic                 use_ay_reg, use_ay_next;
    logic [1:0]           quad_reg;
    logic                 out_valid_reg;
    logic signed [PIX_W-1:0] pixel_x_reg, pixel_y_reg;
    logic [1:0]           quadrant_reg;
    logic                 last_reg, done_reg;

    logic [TX_W-1:0]      tx;
    logic [POS_W-1:0]     ym;
    logic [MA_W-1:0]      mul_a;
    logic [MB_W-1:0]      mul_b;
    logic [PROD_W-1:0]    mul_p;
    logic [DEC_W-1:0]     p_dec, p4, p8, addend4;
    logic [SQ_W-1:0]      addend;
    logic                 dec_neg, dec_zero, dec_pos;
    logic                 out_free, load_pix;
    logic [PIX_W-1:0]     px_sum, px_dif, py_sum, py_dif;

    // region-switch terms: 2x+1 and |y-1| (y-1 squares to 1 when y is zero)
    assign tx = {cur_x_reg, 1'b1};
    assign ym = (cur_y_reg == '0) ? POS_W'(1) : (cur_y_reg - POS_W'(1));

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (dp_cmd.mul_op)
            MUL_AA:
            begin
                mul_a = MA_W'(a_reg);
                mul_b = MB_W'(a_reg);
            end
            MUL_BB:
            begin
                mul_a = MA_W'(cur_y_reg[AXIS_BITS-1:0]);
                mul_b = MB_W'(cur_y_reg[AXIS_BITS-1:0]);
            end
            MUL_A2B:
            begin
                mul_a = a2_reg;
                mul_b = MB_W'(cur_y_reg[AXIS_BITS-1:0]);
            end
            MUL_B2X:
            begin
                mul_a = b2_reg;
                mul_b = MB_W'(cur_x_reg);
            end
            MUL_A2Y:
            begin
                mul_a = a2_reg;
                mul_b = MB_W'(cur_y_reg);
            end
            MUL_TXTX:
            begin
                mul_a = MA_W'(tx);
                mul_b = MB_W'(tx);
            end
            MUL_B2P:
            begin
                mul_a = b2_reg;
                mul_b = p_reg[MB_W-1:0];
            end
            MUL_YMYM:
            begin
                mul_a = MA_W'(ym);
                mul_b = MB_W'(ym);
            end
            MUL_A2P:
            begin
                mul_a = a2_reg;
                mul_b = p_reg[MB_W-1:0];
            end
            MUL_A2B2:
            begin
                mul_a = a2_reg;
                mul_b = MB_W'(b2_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = {{MB_W{1'b0}}, mul_a} * {{MA_W{1'b0}}, mul_b};

    assign p_dec    = DEC_W'(p_reg);
    assign p4       = {p_dec[DEC_W-3:0], 2'b00};
    assign p8       = {p_dec[DEC_W-4:0], 3'b000};
    assign dec_neg  = dec_reg[DEC_W-1];
    assign dec_zero = (dec_reg == '0);
    assign dec_pos  = !dec_neg && !dec_zero;

    // point update: new x and y first, product terms follow over the next cycles
    always_comb
    begin
        cur_x_next  = cur_x_reg;
        cur_y_next  = cur_y_reg;
        use_bx_next = use_bx_reg;
        use_ay_next = use_ay_reg;
        addend      = b2_reg;
        if (!rtwo_reg)
        begin
            addend      = b2_reg;
            use_bx_next = 1'b1;
            use_ay_next = !dec_neg;
            cur_x_next  = cur_x_reg + POS_W'(1);
            if (!dec_neg)
            begin
                cur_y_next = cur_y_reg - POS_W'(1);
            end
        end
        else
        begin
            addend      = a2_reg;
            use_bx_next = !dec_pos;
            use_ay_next = 1'b1;
            cur_y_next  = cur_y_reg - POS_W'(1);
            if (!dec_pos)
            begin
                cur_x_next = cur_x_reg + POS_W'(1);
            end
        end
        if (dp_cmd.load_start)
        begin
            cur_x_next = '0;
            cur_y_next = POS_W'(semi_axis_b);
        end
        else if (!dp_cmd.step_xy)
        begin
            cur_x_next  = cur_x_reg;
            cur_y_next  = cur_y_reg;
            use_bx_next = use_bx_reg;
            use_ay_next = use_ay_reg;
        end
    end

    assign addend4 = DEC_W'({addend, 2'b00});

    always_comb
    begin
        case (dp_cmd.dec_op)
            DEC_START:  dec_next = DEC_W'(a2_reg) + p4;
            DEC_SUB4P:  dec_next = dec_reg - p4;
            DEC_LOADP:  dec_next = p_dec;
            DEC_ADD4P:  dec_next = dec_reg + p4;
            DEC_ADDEND: dec_next = dec_reg + addend4;
            DEC_ADD8P:  dec_next = use_bx_reg ? (dec_reg + p8) : dec_reg;
            DEC_SUB8P:  dec_next = use_ay_reg ? (dec_reg - p8) : dec_reg;
            default:    dec_next = dec_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_x_reg  <= '0;
            cur_y_reg  <= '0;
            dec_reg    <= '0;
            a2_reg     <= '0;
            b2_reg     <= '0;
            rtwo_reg   <= 1'b0;
            use_bx_reg <= 1'b0;
            use_ay_reg <= 1'b0;
        end
        else
        begin
            cur_x_reg  <= cur_x_next;
            cur_y_reg  <= cur_y_next;
            dec_reg    <= dec_next;
            use_bx_reg <= use_bx_next;
            use_ay_reg <= use_ay_next;
            if (dp_cmd.load_a2)
            begin
                a2_reg <= p_reg[SQ_W-1:0];
            end
            if (dp_cmd.load_b2)
            begin
                b2_reg <= p_reg[SQ_W-1:0];
            end
            if (dp_cmd.load_start)
            begin
                rtwo_reg <= 1'b0;
            end
            else if (dp_cmd.set_rtwo)
            begin
                rtwo_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (dp_cmd.load_start)
        begin
            a_reg <= semi_axis_a;
        end
        if (dp_cmd.mul_op != MUL_NONE)
        begin
            p_reg <= mul_p;
        end
        if (dp_cmd.save_t)
        begin
            t_reg <= p_reg;
        end
    end

    // pixel output register, one mirrored pixel per transfer
    assign out_free = !out_valid_reg || !out_stall;
    assign load_pix = dp_cmd.emit && out_free;

    assign px_sum = PIX_W'(center_x) + PIX_W'(cur_x_reg);
    assign px_dif = PIX_W'(center_x) - PIX_W'(cur_x_reg);
    assign py_sum = PIX_W'(center_y) + PIX_W'(cur_y_reg);
    assign py_dif = PIX_W'(center_y) - PIX_W'(cur_y_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            quad_reg      <= QUAD_PP;
        end
        else
        begin
            if (out_free)
            begin
                out_valid_reg <= dp_cmd.emit;
            end
            if (load_pix)
            begin
                quad_reg <= quad_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_pix)
        begin
            pixel_x_reg  <= $signed(quad_reg[0] ? px_dif : px_sum);
            pixel_y_reg  <= $signed(quad_reg[1] ? py_dif : py_sum);
            quadrant_reg <= quad_reg;
            last_reg     <= (quad_reg == QUAD_MM);
            done_reg     <= (cur_y_reg == '0);
        end
    end

    assign out_valid    = out_valid_reg;
    assign pixel_x      = pixel_x_reg;
    assign pixel_y      = pixel_y_reg;
    assign quadrant     = quadrant_reg;
    assign last_of_step = last_reg;
    assign done_res     = done_reg;

    assign stat.gt        = (t_reg > p_reg);
    assign stat.y_zero    = (cur_y_reg == '0);
    assign stat.rtwo      = rtwo_reg;
    assign stat.out_free  = out_free;
    assign stat.emit_last = (quad_reg == QUAD_MM);

endmodule

`default_nettype wire

// File: rtl/midpoint_ellipse_rasterizer.sv
// midpoint_ellipse_rasterizer: top level, center registers on the APB port, sequencer and datapath
// depends on mer_pkg, mer_ctrl, mer_datapath
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+-------------------------------------------
//  in      | input     | in_valid / in_stall  | cmd, semi_axis_a, semi_axis_b
//  out     | output    | out_valid / out_stall| pixel_x, pixel_y, quadrant, last_of_step,
//          |           |                      | done_res
//  apb     | input     | psel / penable       | paddr, pwrite, pwdata, prdata, pready
//
// one 48-bit decision register and one shared multiplier that forms the products in turn:
// a start squares the axes and sets up the decision; a step in region 1 first compares b*b*x
// with a*a*y and, when it crosses into region 2, sets up the region-2 decision; every step
// then emits its four pixels and, unless y is zero, updates the point and the decision.
// emission waits while the output is stalled; in_stall is high from the cycle after an
// accepted start, or a step that is not ignored, until the block is back in idle.
// rst_n is asynchronous; after reset the block is idle and a step is ignored until a start.
`default_nettype none

module midpoint_ellipse_rasterizer
    import mer_pkg::*;
#(
    parameter int AXIS_BITS = AXIS_BITS_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire logic                  cmd,
    input  wire logic [AXIS_BITS-1:0]  semi_axis_a,
    input  wire logic [AXIS_BITS-1:0]  semi_axis_b,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output logic signed [PIX_W-1:0]    pixel_x,
    output logic signed [PIX_W-1:0]    pixel_y,
    output logic [1:0]                 quadrant,
    output logic                       last_of_step,
    output logic                       done_res,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [ADDR_W-1:0]     paddr,
    input  wire logic [DATA_W-1:0]     pwdata,
    output logic [DATA_W-1:0]          prdata,
    output logic                       pready
);

    logic [CENTER_W-1:0] center_x_reg;
    logic [CENTER_W-1:0] center_y_reg;
    ctrl_cmd_t           dp_cmd;
    dp_stat_t            stat;
    logic                cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_x_reg <= CENTER_X_RST;
            center_y_reg <= CENTER_Y_RST;
        end
        else if (cfg_wr)
        begin
            case (paddr[2])
                REG_CENTER_X: center_x_reg <= pwdata[CENTER_W-1:0];
                REG_CENTER_Y: center_y_reg <= pwdata[CENTER_W-1:0];
                default:      center_x_reg <= center_x_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            REG_CENTER_X: prdata = {{(DATA_W-CENTER_W){1'b0}}, center_x_reg};
            REG_CENTER_Y: prdata = {{(DATA_W-CENTER_W){1'b0}}, center_y_reg};
            default:      prdata = '0;
        endcase
    end

    mer_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_cmd   (cmd),
        .in_stall (in_stall),
        .stat     (stat),
        .dp_cmd   (dp_cmd)
    );

    mer_datapath #(
        .AXIS_BITS (AXIS_BITS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .center_x     (center_x_reg),
        .center_y     (center_y_reg),
        .semi_axis_a  (semi_axis_a),
        .semi_axis_b  (semi_axis_b),
        .dp_cmd       (dp_cmd),
        .stat         (stat),
        .out_stall    (out_stall),
        .out_valid    (out_valid),
        .pixel_x      (pixel_x),
        .pixel_y      (pixel_y),
        .quadrant     (quadrant),
        .last_of_step (last_of_step),
        .done_res     (done_res)
    );

endmodule

`default_nettype wire

// File: rtl/mer_checker.sv
// mer_checker: port-level assertions for the ellipse rasterizer, bound to the top level
// depends on mer_pkg and midpoint_ellipse_rasterizer
`default_nettype none

module mer_checker
    import mer_pkg::*;
(
    input wire logic                clk,
    input wire logic                rst_n,
    input wire logic                in_valid,
    input wire logic                in_stall,
    input wire logic                cmd,
    input wire logic                out_valid,
    input wire logic                out_stall,
    input wire logic [PIX_W-1:0]    pixel_x,
    input wire logic [PIX_W-1:0]    pixel_y,
    input wire logic [1:0]          quadrant,
    input wire logic                last_of_step,
    input wire logic                done_res
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(pixel_x) && $stable(pixel_y)
            && $stable(quadrant) && $stable(last_of_step) && $stable(done_res))
        else $error("stalled result changed");

    // the fourth pixel of a step carries the last flag, no other
    a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (last_of_step == (quadrant == QUAD_MM)))
        else $error("last_of_step does not match quadrant");

    // a start keeps the input side stalled while the axis squares are formed
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && (cmd == CMD_START) |=> in_stall)
        else $error("input taken during start setup");

    // while a step is being emitted no new item is taken
    a_emit_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && (quadrant == QUAD_PP) |=> in_stall)
        else $error("input taken in the middle of a step");

endmodule

bind midpoint_ellipse_rasterizer mer_checker u_mer_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .cmd          (cmd),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .pixel_x      (pixel_x),
    .pixel_y      (pixel_y),
    .quadrant     (quadrant),
    .last_of_step (last_of_step),
    .done_res     (done_res)
);

`default_nettype wire

// File: tb/sv/midpoint_ellipse_rasterizer_test.sv
// midpoint_ellipse_rasterizer_test: self-checking bench for the midpoint ellipse rasterizer
// traces each ellipse in step with the block and checks every mirrored pixel it returns
// depends on mer_pkg and midpoint_ellipse_rasterizer
module midpoint_ellipse_rasterizer_test;
    import mer_pkg::*;

    localparam int AB_W          = AXIS_BITS_DEF;
    localparam int POS_W         = AXIS_BITS_DEF + 1;
    localparam int STALL_LIMIT   = 20000;
    localparam int SETTLE_CYCLES = 40;
    localparam int PHASE_CMDS    = 55;
    localparam logic [63:0] DEC_MASK = (64'd1 << DEC_W) - 64'd1;

    typedef struct packed {
        logic            op;
        logic [AB_W-1:0] a;
        logic [AB_W-1:0] b;
    } axis_cmd_t;

    typedef struct packed {
        logic signed [PIX_W-1:0] px;
        logic signed [PIX_W-1:0] py;
        logic [1:0]              quad;
        logic                    last;
        logic                    done;
    } pixel_t;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    in_valid = 1'b0;
    logic                    in_stall;
    logic                    cmd = CMD_START;
    logic [AB_W-1:0]         semi_axis_a = '0;
    logic [AB_W-1:0]         semi_axis_b = '0;
    logic                    out_valid;
    logic                    out_stall = 1'b0;
    logic signed [PIX_W-1:0] pixel_x;
    logic signed [PIX_W-1:0] pixel_y;
    logic [1:0]              quadrant;
    logic                    last_of_step;
    logic                    done_res;
    logic                    psel = 1'b0;
    logic                    penable = 1'b0;
    logic                    pwrite = 1'b0;
    logic [ADDR_W-1:0]       paddr = '0;
    logic [DATA_W-1:0]       pwdata = '0;
    logic [DATA_W-1:0]       prdata;
    logic                    pready;

    // traced ellipse state
    logic [CENTER_W-1:0] ctr_x = CENTER_X_RST;
    logic [CENTER_W-1:0] ctr_y = CENTER_Y_RST;
    logic [POS_W-1:0]    pos_x = '0;
    logic [POS_W-1:0]    pos_y = '0;
    logic [63:0]         dec = '0;
    logic [63:0]         sq_a = '0;
    logic [63:0]         sq_b = '0;
    logic                in_r2 = 1'b0;
    logic                tracing = 1'b0;

    axis_cmd_t cmd_q[$];
    pixel_t    pixel_q[$];

    int   live_cmd_cnt = 0;
    int   mismatch_cnt = 0;
    int   quiet_cycles = 0;
    int   send_idle_pct = 0;
    int   stall_pct = 0;
    logic hold_send = 1'b0;
    logic in_fire = 1'b0;
    logic out_clear = 1'b0;
    logic all_clear = 1'b0;

    midpoint_ellipse_rasterizer dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .cmd          (cmd),
        .semi_axis_a  (semi_axis_a),
        .semi_axis_b  (semi_axis_b),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .pixel_x      (pixel_x),
        .pixel_y      (pixel_y),
        .quadrant     (quadrant),
        .last_of_step (last_of_step),
        .done_res     (done_res),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always #5 clk = ~clk;

    function automatic pixel_t mirror(input logic neg_x, input logic neg_y,
                                      input logic [1:0] quad, input logic fin,
                                      input logic last);
        pixel_t p;
        p.px   = neg_x ? {2'b00, ctr_x} - {2'b00, pos_x} : {2'b00, ctr_x} + {2'b00, pos_x};
        p.py   = neg_y ? {2'b00, ctr_y} - {2'b00, pos_y} : {2'b00, ctr_y} + {2'b00, pos_y};
        p.quad = quad;
        p.last = last;
        p.done = fin;
        return p;
    endfunction

    // advances the traced ellipse by one transfer and queues the pixels it yields
    task automatic trace_point(input axis_cmd_t c);
        logic [63:0] x64;
        logic [63:0] y64;
        logic [63:0] tx;
        logic [63:0] ym1;
        logic        fin;
        logic        dec_pos;
        if (c.op == CMD_START) begin
            sq_a    = c.a * c.a;
            sq_b    = c.b * c.b;
            pos_x   = '0;
            pos_y   = POS_W'(c.b);
            dec     = (4 * sq_b - 4 * sq_a * c.b + sq_a) & DEC_MASK;
            in_r2   = 1'b0;
            tracing = 1'b1;
            live_cmd_cnt++;
        end else if (tracing) begin
            live_cmd_cnt++;
            x64 = pos_x;
            y64 = pos_y;
            // region switch is decided at the current point, before it goes out
            if (!in_r2 && sq_b * x64 > sq_a * y64) begin
                tx    = 2 * x64 + 1;
                ym1   = y64 - 1;
                in_r2 = 1'b1;
                dec   = (sq_b * tx * tx + 4 * sq_a * ym1 * ym1 - 4 * sq_a * sq_b) & DEC_MASK;
            end
            fin = (pos_y == 0);
            pixel_q.push_back(mirror(1'b0, 1'b0, QUAD_PP, fin, 1'b0));
            pixel_q.push_back(mirror(1'b1, 1'b0, QUAD_MP, fin, 1'b0));
            pixel_q.push_back(mirror(1'b0, 1'b1, QUAD_PM, fin, 1'b0));
            pixel_q.push_back(mirror(1'b1, 1'b1, QUAD_MM, fin, 1'b1));
            if (fin)
                tracing = 1'b0;
            else if (!in_r2) begin
                pos_x = pos_x + POS_W'(1);
                x64   = pos_x;
                if (dec[DEC_W-1])
                    dec = dec + 4 * (2 * sq_b * x64 + sq_b);
                else begin
                    pos_y = pos_y - POS_W'(1);
                    y64   = pos_y;
                    dec   = dec + 4 * (2 * sq_b * x64 - 2 * sq_a * y64 + sq_b);
                end
            end else begin
                dec_pos = !dec[DEC_W-1] && dec != 0;
                pos_y   = pos_y - POS_W'(1);
                y64     = pos_y;
                if (dec_pos)
                    dec = dec + 4 * (sq_a - 2 * sq_a * y64);
                else begin
                    pos_x = pos_x + POS_W'(1);
                    x64   = pos_x;
                    dec   = dec + 4 * (2 * sq_b * x64 - 2 * sq_a * y64 + sq_a);
                end
            end
            dec = dec & DEC_MASK;
        end
    endtask

    task automatic cmp_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatch_cnt++;
        end
    endtask

    // input side, checker and watchdog
    always @(posedge clk)
    begin
        pixel_t got;
        pixel_t want;
        in_fire <= rst_n && in_valid && !in_stall;
        if (rst_n && in_valid && !in_stall)
            trace_point({cmd, semi_axis_a, semi_axis_b});
        if (rst_n && out_valid && !out_stall) begin
            got = {pixel_x, pixel_y, quadrant, last_of_step, done_res};
            if (pixel_q.size() == 0) begin
                $error("pixel with no expectation: x %0d y %0d", pixel_x, pixel_y);
                mismatch_cnt++;
            end else begin
                want = pixel_q.pop_front();
                if ($isunknown(got)) begin
                    $error("pixel: expected known fields, got %h", got);
                    mismatch_cnt++;
                end else begin
                    cmp_field("pixel_x", want.px, got.px);
                    cmp_field("pixel_y", want.py, got.py);
                    cmp_field("quadrant", want.quad, got.quad);
                    cmp_field("last_of_step", want.last, got.last);
                    cmp_field("done_res", want.done, got.done);
                end
            end
        end
        out_clear <= !in_valid && pixel_q.size() == 0;
        all_clear <= !in_valid && pixel_q.size() == 0 && cmd_q.size() == 0;
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else if (quiet_cycles == STALL_LIMIT) begin
            $display("simulation failed");
            $finish;
        end else
            quiet_cycles <= quiet_cycles + 1;
    end

    // driver and output stall
    always @(negedge clk)
    begin
        axis_cmd_t nxt;
        if (!in_valid || in_fire) begin
            if (cmd_q.size() != 0 && !hold_send && $urandom_range(99) >= send_idle_pct) begin
                nxt = cmd_q.pop_front();
                cmd         <= nxt.op;
                semi_axis_a <= nxt.a;
                semi_axis_b <= nxt.b;
                in_valid    <= 1'b1;
            end else
                in_valid <= 1'b0;
        end
        out_stall <= $urandom_range(99) < stall_pct;
    end

    task automatic put_cmd(input logic op, input int a, input int b);
        cmd_q.push_back('{op, AB_W'(a), AB_W'(b)});
    endtask

    task automatic put_ellipse(input int a, input int b, input int steps);
        put_cmd(CMD_START, a, b);
        repeat (steps) put_cmd(CMD_STEP, a, b);
    endtask

    // mostly complete ellipses of small size; some cut short, some noise
    task automatic queue_sequence();
        int kind;
        int a;
        int b;
        int n;
        kind = $urandom_range(99);
        if (kind < 10) begin
            repeat ($urandom_range(4, 1))
                put_cmd($urandom_range(1), $urandom_range(1023), $urandom_range(1023));
        end else begin
            if (kind < 80) begin
                a = $urandom_range(12);
                b = $urandom_range(12);
            end else if (kind < 95) begin
                a = $urandom_range(40);
                b = $urandom_range(40);
            end else begin
                a = $urandom_range(1023);
                b = $urandom_range(1023);
            end
            // enough steps to finish, plus spares that land while idle
            n = (kind < 95) ? a + b + 3 : $urandom_range(6, 1);
            if ($urandom_range(9) == 0)
                n = $urandom_range(n);
            put_ellipse(a, b, n);
        end
    endtask

    task automatic drain();
        repeat (2) @(negedge clk);
        while (!all_clear) @(negedge clk);
        // a start or an ignored step may still be in flight
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_center(input logic sel, input logic [CENTER_W-1:0] val);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {sel, 2'b00};
        pwdata  <= DATA_W'(val);
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (sel == REG_CENTER_X)
            ctr_x = val;
        else
            ctr_y = val;
    endtask

    task automatic run_phase(input int idle_pct, input int stall,
                             input logic [CENTER_W-1:0] cx, input logic [CENTER_W-1:0] cy);
        int   stop_at;
        logic held;
        drain();
        write_center(REG_CENTER_X, cx);
        write_center(REG_CENTER_Y, cy);
        send_idle_pct = idle_pct;
        stall_pct     = stall;
        stop_at       = live_cmd_cnt + PHASE_CMDS;
        held          = 1'b0;
        while (live_cmd_cnt < stop_at) begin
            if (cmd_q.size() < 4)
                queue_sequence();
            // halfway through, let every pending pixel come out before sending more
            if (!held && live_cmd_cnt > stop_at - PHASE_CMDS / 2) begin
                held      = 1'b1;
                hold_send = 1'b1;
                repeat (2) @(negedge clk);
                while (!out_clear) @(negedge clk);
                hold_send = 1'b0;
            end
            @(negedge clk);
        end
    endtask

    initial
    begin
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;

        put_cmd(CMD_STEP, 1023, 1023);
        put_ellipse(1023, 1023, 2);
        put_ellipse(0, 0, 2);
        put_ellipse(0, 3, 4);
        put_ellipse(1023, 1, 2);
        put_ellipse(1, 1023, 2);
        put_ellipse(3, 2, 7);

        run_phase(0, 0, '0, '1);
        run_phase(68, 0, '1, '0);
        run_phase(0, 68, CENTER_W'($urandom_range(2047)), CENTER_W'($urandom_range(2047)));
        run_phase(16, 16, CENTER_X_RST, CENTER_Y_RST);
        drain();

        if (mismatch_cnt == 0 && pixel_q.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
